@@ sv/pedestal_subtract_window_integrator_top_defines.svh @@
// Assertion macro used by the integrator RTL.
`ifndef PEDESTAL_SUBTRACT_WINDOW_INTEGRATOR_TOP_DEFINES_SVH
`define PEDESTAL_SUBTRACT_WINDOW_INTEGRATOR_TOP_DEFINES_SVH
// Clocked check, off during reset.
`define PSWI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`endif

@@ sv/pswi_pkg.sv @@
// Types and constants of the pedestal subtract window integrator.
package pswi_pkg;
	localparam int NUM_REGS = 8;
	localparam int MOD_W = 12;
	localparam int MM_W = 11;

	typedef enum logic [1:0] {
		OP_PED = 2'd0,
		OP_HDR = 2'd1,
		OP_SMP = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_HDR, ST_SUB, ST_DIST, ST_WS, ST_WE, ST_CHI, ST_ACC, ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic        bank;
		logic [7:0]  ring_position;
		logic [3:0]  channel;
		logic [15:0] value;
		logic [7:0]  first_sample;
		logic [7:0]  sample_count;
		logic [7:0]  trigger_sample;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         window_index;
		logic [3:0]         out_channel;
		logic signed [23:0] integral_sum;
		logic               last_result;
	} out_beat_t;

	function automatic logic signed [MOD_W-1:0] ext9(input logic signed [8:0] v);
		return {{(MOD_W-9){v[8]}}, v};
	endfunction
endpackage

@@ sv/pedestal_subtract_window_integrator_top.sv @@
// Top level: pedestal subtraction into a difference memory and windowed integration.
// Pedestal beats write one word; a header reduces first_sample modulo the ring depth.
// A sample is read from pedestal memory, then subtracted and stored.
// The last sample of a packet starts integration: modulo steps find each window start
// and end, then each channel is summed; one strobe per channel and window, 64 in all.
// Results cannot be stalled. arst_n clears control state; memories are not cleared.
`include "pedestal_subtract_window_integrator_top_defines.svh"
module pedestal_subtract_window_integrator_top #(
	parameter int CHANNELS = 16,
	parameter int RING_DEPTH = 256,
	parameter int BANKS = 2,
	parameter int WINDOWS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  pswi_pkg::in_beat_t  in,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [8:0]          cfg_data,
	output logic                result_valid,
	output pswi_pkg::out_beat_t result
);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int BW = (BANKS > 1) ? $clog2(BANKS) : 1;
	localparam int PW = $clog2(RING_DEPTH);
	localparam int PAW = $clog2(BANKS * RING_DEPTH * CHANNELS);
	localparam int DAW = $clog2(RING_DEPTH * CHANNELS);

	// memories: pedestal words and per-packet differences
	logic [15:0] ped_mem [BANKS*RING_DEPTH*CHANNELS];
	logic [15:0] diff_mem [RING_DEPTH*CHANNELS];
	logic [15:0] ped_rd_q, diff_rd_q;

	pswi_pkg::state_t state_q, state_nx;
	logic signed [8:0] win_q [pswi_pkg::NUM_REGS];

	logic [BW-1:0] bank_q;
	logic [PW-1:0] first_q, pos_q;
	logic [7:0]    len_m1_q, trig_q, sc_q;
	logic [CW-1:0] cc_q, c_q;
	logic [15:0]   raw_q;

	// shared modulo stepper: one add or subtract per cycle while in a modulo state and not done
	logic signed [pswi_pkg::MOD_W-1:0] mx_q;
	logic [pswi_pkg::MM_W-1:0] mm_q;
	logic mod_done;

	logic [PW-1:0] dist_q;
	logic [1:0]    w_q;
	logic [7:0]    s_q;
	logic [8:0]    cnt_q, n_q, j_q;
	logic          rv_q;
	logic signed [23:0] sum_q;

	logic [8:0] len;
	logic accept, pkt_end, mod_en;
	logic signed [pswi_pkg::MOD_W-1:0] dist_ext;
	logic [2:0] ws_idx, we_idx, nws_idx;

	assign accept = start && !busy;
	assign len = {1'b0, len_m1_q} + 9'd1;
	assign mod_done = !mx_q[pswi_pkg::MOD_W-1] &&
		(mx_q < $signed({1'b0, mm_q}));
	assign pkt_end = (cc_q == CW'(CHANNELS-1)) && (sc_q >= len_m1_q);
	assign dist_ext = $signed({{(pswi_pkg::MOD_W-PW){1'b0}}, dist_q});
	assign ws_idx = {w_q, 1'b0};
	assign we_idx = {w_q, 1'b1};
	assign nws_idx = {w_q + 2'd1, 1'b0};
	assign mod_en = (state_q == pswi_pkg::ST_HDR) || (state_q == pswi_pkg::ST_DIST) ||
		(state_q == pswi_pkg::ST_WS) || (state_q == pswi_pkg::ST_WE);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			pswi_pkg::ST_IDLE: begin
				if (accept && in.op == pswi_pkg::OP_HDR)
					state_nx = pswi_pkg::ST_HDR;
				else if (accept && in.op == pswi_pkg::OP_SMP)
					state_nx = pswi_pkg::ST_SUB;
			end
			pswi_pkg::ST_HDR:  if (mod_done) state_nx = pswi_pkg::ST_IDLE;
			pswi_pkg::ST_SUB:  state_nx = pkt_end ? pswi_pkg::ST_DIST : pswi_pkg::ST_IDLE;
			pswi_pkg::ST_DIST: if (mod_done) state_nx = pswi_pkg::ST_WS;
			pswi_pkg::ST_WS:   if (mod_done) state_nx = pswi_pkg::ST_WE;
			pswi_pkg::ST_WE:   if (mod_done) state_nx = pswi_pkg::ST_CHI;
			pswi_pkg::ST_CHI:  state_nx = pswi_pkg::ST_ACC;
			pswi_pkg::ST_ACC:  if (n_q == cnt_q && !rv_q) state_nx = pswi_pkg::ST_EMIT;
			pswi_pkg::ST_EMIT: begin
				if (c_q != CW'(CHANNELS-1))
					state_nx = pswi_pkg::ST_CHI;
				else if (w_q != 2'(WINDOWS-1))
					state_nx = pswi_pkg::ST_WS;
				else
					state_nx = pswi_pkg::ST_IDLE;
			end
			default: state_nx = pswi_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != pswi_pkg::ST_IDLE);
		result_valid = (state_q == pswi_pkg::ST_EMIT);
		result.window_index = w_q;
		result.out_channel = 4'(c_q);
		result.integral_sum = sum_q;
		result.last_result = (w_q == 2'(WINDOWS-1)) && (c_q == CW'(CHANNELS-1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pswi_pkg::ST_IDLE;
			for (int i = 0; i < pswi_pkg::NUM_REGS; i++) win_q[i] <= '0;
			bank_q <= '0;
			first_q <= '0;
			pos_q <= '0;
			len_m1_q <= '0;
			trig_q <= '0;
			sc_q <= '0;
			cc_q <= '0;
			rv_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) win_q[cfg_index] <= $signed(cfg_data);
			rv_q <= 1'b0;
			case (state_q)
				pswi_pkg::ST_IDLE: begin
					if (accept && in.op == pswi_pkg::OP_HDR) begin
						bank_q <= (int'(in.bank) < BANKS) ? BW'(in.bank) : '0;
						len_m1_q <= (int'(in.sample_count) > RING_DEPTH-1) ?
							8'(RING_DEPTH-1) : in.sample_count;
						trig_q <= in.trigger_sample;
						sc_q <= '0;
						cc_q <= '0;
					end
				end
				pswi_pkg::ST_HDR: begin
					if (mod_done) begin
						first_q <= PW'(mx_q);
						pos_q <= PW'(mx_q);
					end
				end
				pswi_pkg::ST_SUB: begin
					if (pkt_end) begin
						sc_q <= '0;
						cc_q <= '0;
						pos_q <= first_q;
					end else if (cc_q == CW'(CHANNELS-1)) begin
						cc_q <= '0;
						sc_q <= sc_q + 8'd1;
						pos_q <= (pos_q == PW'(RING_DEPTH-1)) ? '0 : pos_q + PW'(1);
					end else begin
						cc_q <= cc_q + CW'(1);
					end
				end
				pswi_pkg::ST_ACC: rv_q <= (n_q != cnt_q);
				default: ;
			endcase
		end
	end

	// modulo stepper, sample latch and integration datapath, no reset needed
	always_ff @(posedge clk) begin
		if (mod_en && !mod_done)
			mx_q <= mx_q[pswi_pkg::MOD_W-1] ? mx_q + $signed({1'b0, mm_q}) :
				mx_q - $signed({1'b0, mm_q});
		case (state_q)
			pswi_pkg::ST_IDLE: begin
				raw_q <= in.value;
				if (accept && in.op == pswi_pkg::OP_HDR) begin
					mx_q <= $signed({{(pswi_pkg::MOD_W-8){1'b0}}, in.first_sample});
					mm_q <= pswi_pkg::MM_W'(RING_DEPTH);
				end
			end
			pswi_pkg::ST_SUB: begin
				mx_q <= $signed({{(pswi_pkg::MOD_W-8){1'b0}}, trig_q}) -
					$signed({{(pswi_pkg::MOD_W-PW){1'b0}}, first_q});
				mm_q <= pswi_pkg::MM_W'(RING_DEPTH);
				w_q <= '0;
			end
			pswi_pkg::ST_DIST: begin
				if (mod_done) begin
					dist_q <= PW'(mx_q);
					mx_q <= $signed({{(pswi_pkg::MOD_W-PW){1'b0}}, PW'(mx_q)}) +
						pswi_pkg::ext9(win_q[ws_idx]);
					mm_q <= pswi_pkg::MM_W'(len);
				end
			end
			pswi_pkg::ST_WS: begin
				if (mod_done) begin
					s_q <= 8'(mx_q);
					mx_q <= dist_ext + pswi_pkg::ext9(win_q[we_idx]);
				end
			end
			pswi_pkg::ST_WE: begin
				if (mod_done) begin
					cnt_q <= (8'(mx_q) >= s_q) ? {1'b0, 8'(mx_q)} - {1'b0, s_q} + 9'd1 :
						len - {1'b0, s_q} + {1'b0, 8'(mx_q)} + 9'd1;
					c_q <= '0;
				end
			end
			pswi_pkg::ST_CHI: begin
				j_q <= {1'b0, s_q};
				n_q <= '0;
				sum_q <= '0;
			end
			pswi_pkg::ST_ACC: begin
				if (n_q != cnt_q) begin
					n_q <= n_q + 9'd1;
					j_q <= (j_q + 9'd1 == len) ? '0 : j_q + 9'd1;
				end
				if (rv_q) sum_q <= sum_q + 24'($signed(diff_rd_q));
			end
			pswi_pkg::ST_EMIT: begin
				if (c_q != CW'(CHANNELS-1)) begin
					c_q <= c_q + CW'(1);
				end else begin
					c_q <= '0;
					w_q <= w_q + 2'd1;
					mx_q <= dist_ext + pswi_pkg::ext9(win_q[nws_idx]);
				end
			end
			default: ;
		endcase
	end

	// pedestal memory: write from pedestal beats, read for samples
	always_ff @(posedge clk) begin
		if (accept && in.op == pswi_pkg::OP_PED && int'(in.ring_position) < RING_DEPTH &&
			int'(in.channel) < CHANNELS)
			ped_mem[PAW'((((int'(in.bank) < BANKS) ? int'(in.bank) : 0) * RING_DEPTH +
				int'(in.ring_position)) * CHANNELS + int'(in.channel))] <= in.value;
		ped_rd_q <= ped_mem[PAW'((int'(bank_q) * RING_DEPTH + int'(pos_q)) * CHANNELS +
			int'(cc_q))];
	end

	// difference memory: write at subtract, read during accumulation
	always_ff @(posedge clk) begin
		if (state_q == pswi_pkg::ST_SUB)
			diff_mem[DAW'(int'(sc_q) * CHANNELS + int'(cc_q))] <= raw_q - ped_rd_q;
		diff_rd_q <= diff_mem[DAW'(int'(j_q) * CHANNELS + int'(c_q))];
	end

	`PSWI_ASSERT(a_strobe_single, result_valid |=> !result_valid, "result strobe held")
	`PSWI_ASSERT(a_last_ends, (result_valid && result.last_result) |=> !busy,
		"block busy after last result")
	`PSWI_ASSERT(a_count_fits, (state_q == pswi_pkg::ST_ACC) |-> (n_q <= cnt_q && cnt_q <= len),
		"window count overrun")
	`PSWI_ASSERT(a_sample_range, !busy |-> (sc_q <= len_m1_q),
		"sample counter past packet length")
endmodule
